FILE: rtl/bounded_sorted_list_engine_core_macros.svh
// Assertion macros for the bounded sorted list engine.
// Included by the modules that carry assertions; depends on nothing else.
`ifndef BOUNDED_SORTED_LIST_ENGINE_CORE_MACROS_SVH
`define BOUNDED_SORTED_LIST_ENGINE_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, sampled on the rising clock edge outside reset.
`define BSLE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on the rising clock edge outside reset.
`define BSLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BSLE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define BSLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/bsle_pkg.sv
// Shared constants, codes and types of the bounded sorted list engine.
// Used by bsle_cell and bounded_sorted_list_engine_core; depends on nothing.
`timescale 1ns / 1ps

package bsle_pkg;

    // Default sizes and fixed port widths.
    localparam int DEPTH_DEF       = 16;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int PORT_VW         = 32;
    localparam int COUNT_W         = 5;
    localparam int MODE_W          = 3;
    localparam int STATUS_W        = 2;

    typedef logic [MODE_W-1:0]   t_mode;
    typedef logic [STATUS_W-1:0] t_status;

    // Operation codes.
    localparam t_mode MODE_INS_HEAD = 3'd0;
    localparam t_mode MODE_INS_TAIL = 3'd1;
    localparam t_mode MODE_RM_HEAD  = 3'd2;
    localparam t_mode MODE_RM_TAIL  = 3'd3;
    localparam t_mode MODE_INS_SORT = 3'd4;
    localparam t_mode MODE_RM_VALUE = 3'd5;
    localparam t_mode MODE_CLEAR    = 3'd6;

    // Status codes.
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_FULL      = 2'd1;
    localparam t_status ST_EMPTY     = 2'd2;
    localparam t_status ST_NOT_FOUND = 2'd3;

    // Control handed from the sequencer to every cell.
    typedef struct packed {
        t_mode mode;
        logic  ins_en;
        logic  rm_en;
    } t_cell_ctl;

endpackage

FILE: rtl/bounded_sorted_list_engine_core.sv
// Bounded sorted list engine: a chain of DEPTH cells holding an ordered list.
// The result strobe is registered and follows the shift and read-out steps.
// A new item is taken only after the shift and read-out steps; busy is high during them.
// The receiver cannot stall; results appear for one cycle on o_valid.
// Reset (synchronous, active low) empties the list; cell contents are kept.
`timescale 1ns / 1ps

`include "bounded_sorted_list_engine_core_macros.svh"

module bounded_sorted_list_engine_core #(
    parameter int DEPTH       = bsle_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = bsle_pkg::VALUE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [bsle_pkg::MODE_W-1:0]    i_mode,
    input  logic [bsle_pkg::PORT_VW-1:0]   i_value,
    output logic                           o_valid,
    output logic [bsle_pkg::STATUS_W-1:0]  o_status,
    output logic [bsle_pkg::PORT_VW-1:0]   o_head_value,
    output logic [bsle_pkg::PORT_VW-1:0]   o_tail_value,
    output logic [bsle_pkg::COUNT_W-1:0]   o_count
);

    localparam int CW = $clog2(DEPTH+1);
    localparam int PVW = bsle_pkg::PORT_VW;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_APPLY = 2'd1;
    localparam logic [1:0] S_RES   = 2'd2;

    logic [1:0]               r_state;
    logic [1:0]               n_state;
    bsle_pkg::t_mode          r_mode;
    logic [VALUE_WIDTH-1:0]   r_value;
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;
    bsle_pkg::t_status        r_status;
    bsle_pkg::t_status        n_status;
    logic                     r_o_valid;
    bsle_pkg::t_status        r_o_status;
    logic [PVW-1:0]           r_o_head;
    logic [PVW-1:0]           r_o_tail;
    logic [bsle_pkg::COUNT_W-1:0] r_o_count;

    logic                     w_accept;
    logic [VALUE_WIDTH-1:0]   w_in_value;
    bsle_pkg::t_cell_ctl      w_ctl;
    logic                     w_full;
    logic                     w_empty;
    logic                     w_is_ins;
    logic                     w_is_rm;
    logic                     w_found;
    logic [VALUE_WIDTH-1:0]   w_data [DEPTH];
    logic [VALUE_WIDTH-1:0]   w_prev [DEPTH];
    logic [VALUE_WIDTH-1:0]   w_next [DEPTH];
    logic                     w_before [DEPTH];
    logic                     w_after  [DEPTH];
    logic [VALUE_WIDTH-1:0]   w_head;
    logic [VALUE_WIDTH-1:0]   w_tail;
    logic [PVW-1:0]           w_head_port;
    logic [PVW-1:0]           w_tail_port;

    assign w_accept = start && !busy;
    assign busy     = r_state != S_IDLE;

    // Bring the port value to the stored width, and stored values back to the port.
    generate
        if (VALUE_WIDTH <= PVW) begin : g_in_narrow
            assign w_in_value = i_value[VALUE_WIDTH-1:0];
        end else begin : g_in_wide
            assign w_in_value = {{(VALUE_WIDTH-PVW){i_value[PVW-1]}}, i_value};
        end
        if (VALUE_WIDTH >= PVW) begin : g_out_wide
            assign w_head_port = w_head[PVW-1:0];
            assign w_tail_port = w_tail[PVW-1:0];
        end else begin : g_out_narrow
            assign w_head_port = {{(PVW-VALUE_WIDTH){w_head[VALUE_WIDTH-1]}}, w_head};
            assign w_tail_port = {{(PVW-VALUE_WIDTH){w_tail[VALUE_WIDTH-1]}}, w_tail};
        end
    endgenerate

    // Classify the operation and gate it on fill level.
    assign w_full   = r_count == CW'(DEPTH);
    assign w_empty  = r_count == '0;
    assign w_is_ins = (r_mode == bsle_pkg::MODE_INS_HEAD) || (r_mode == bsle_pkg::MODE_INS_TAIL)
                   || (r_mode == bsle_pkg::MODE_INS_SORT);
    assign w_is_rm  = (r_mode == bsle_pkg::MODE_RM_HEAD) || (r_mode == bsle_pkg::MODE_RM_TAIL)
                   || (r_mode == bsle_pkg::MODE_RM_VALUE);

    always_comb begin
        w_ctl.mode   = r_mode;
        w_ctl.ins_en = (r_state == S_APPLY) && w_is_ins && !w_full;
        w_ctl.rm_en  = (r_state == S_APPLY) && w_is_rm && !w_empty;
    end

    // Wire the chain: data passes to both neighbours, the match flag ripples down.
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            if (gi == 0) begin : g_first
                assign w_prev[gi]   = '0;
                assign w_before[gi] = 1'b0;
            end else begin : g_mid
                assign w_prev[gi]   = w_data[gi-1];
                assign w_before[gi] = w_after[gi-1];
            end
            if (gi == DEPTH-1) begin : g_last
                assign w_next[gi] = '0;
            end else begin : g_inner
                assign w_next[gi] = w_data[gi+1];
            end

            bsle_cell #(
                .DEPTH       (DEPTH),
                .VALUE_WIDTH (VALUE_WIDTH),
                .INDEX       (gi)
            ) u_cell (
                .i_clk       (i_clk),
                .i_cap       (w_accept),
                .i_cmp_value (w_in_value),
                .i_ins_value (r_value),
                .i_ctl       (w_ctl),
                .i_count     (r_count),
                .i_prev_data (w_prev[gi]),
                .i_next_data (w_next[gi]),
                .i_before    (w_before[gi]),
                .o_after     (w_after[gi]),
                .o_data      (w_data[gi])
            );
        end
    endgenerate

    assign w_found = w_after[DEPTH-1];

    // Status and new fill level of the operation being applied.
    always_comb begin
        n_status = bsle_pkg::ST_OK;
        n_count  = r_count;
        if (w_is_ins) begin
            if (w_full) begin
                n_status = bsle_pkg::ST_FULL;
            end else begin
                n_count = r_count + CW'(1);
            end
        end else if (w_is_rm) begin
            if (w_empty) begin
                n_status = bsle_pkg::ST_EMPTY;
            end else if ((r_mode == bsle_pkg::MODE_RM_VALUE) && !w_found) begin
                n_status = bsle_pkg::ST_NOT_FOUND;
            end else begin
                n_count = r_count - CW'(1);
            end
        end else if (r_mode == bsle_pkg::MODE_CLEAR) begin
            n_count = '0;
        end
    end

    // Head is the first cell; tail is picked out of the chain by position.
    always_comb begin
        w_head = w_empty ? '0 : w_data[0];
        w_tail = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (!w_empty && (CW'(k) == (r_count - CW'(1)))) begin
                w_tail = w_tail | w_data[k];
            end
        end
    end

    // Sequencer: accept, apply the shift, then read out the result.
    always_comb begin
        unique case (r_state)
            S_IDLE:  n_state = w_accept ? S_APPLY : S_IDLE;
            S_APPLY: n_state = S_RES;
            S_RES:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= r_state == S_RES;
            if (r_state == S_APPLY) begin
                r_count <= n_count;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode  <= i_mode;
            r_value <= w_in_value;
        end
        if (r_state == S_APPLY) begin
            r_status <= n_status;
        end
        if (r_state == S_RES) begin
            r_o_status <= r_status;
            r_o_head   <= w_head_port;
            r_o_tail   <= w_tail_port;
            r_o_count  <= r_count[bsle_pkg::COUNT_W-1:0];
        end
    end

    assign o_valid      = r_o_valid;
    assign o_status     = r_o_status;
    assign o_head_value = r_o_head;
    assign o_tail_value = r_o_tail;
    assign o_count      = r_o_count;

    // An accepted item always moves the sequencer on to the shift step.
    `BSLE_ASSERT_NEXT(a_accept_applies, i_clk, i_rst_n, w_accept, r_state == S_APPLY,
                      "accepted item did not reach the shift step")
    // The read-out step is always followed by a result strobe.
    `BSLE_ASSERT_NEXT(a_res_strobes, i_clk, i_rst_n, r_state == S_RES, o_valid,
                      "result strobe missing after read-out")
    // The fill level never exceeds the number of cells.
    `BSLE_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH),
                     "fill level beyond depth")
    // A dropped insert is only reported when the list is full.
    `BSLE_ASSERT_NOW(a_full_status, i_clk, i_rst_n,
                     o_valid && (o_status == bsle_pkg::ST_FULL), r_count == CW'(DEPTH),
                     "full status with free cells")
    // An empty no-op is only reported when the list is empty.
    `BSLE_ASSERT_NOW(a_empty_status, i_clk, i_rst_n,
                     o_valid && (o_status == bsle_pkg::ST_EMPTY), r_count == '0,
                     "empty status with stored items")

endmodule

FILE: rtl/bsle_cell.sv
// One storage cell of the list chain: holds one element, compares it with the
// operand and shifts towards either neighbour. Depends on bsle_pkg.
`timescale 1ns / 1ps

module bsle_cell #(
    parameter int DEPTH       = bsle_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = bsle_pkg::VALUE_WIDTH_DEF,
    parameter int INDEX       = 0
) (
    input  logic                     i_clk,
    input  logic                     i_cap,
    input  logic [VALUE_WIDTH-1:0]   i_cmp_value,
    input  logic [VALUE_WIDTH-1:0]   i_ins_value,
    input  bsle_pkg::t_cell_ctl      i_ctl,
    input  logic [$clog2(DEPTH+1)-1:0] i_count,
    input  logic [VALUE_WIDTH-1:0]   i_prev_data,
    input  logic [VALUE_WIDTH-1:0]   i_next_data,
    input  logic                     i_before,
    output logic                     o_after,
    output logic [VALUE_WIDTH-1:0]   o_data
);

    localparam int CW = $clog2(DEPTH+1);
    localparam logic [CW-1:0] IDX_C = CW'(INDEX);

    logic [VALUE_WIDTH-1:0] r_data;
    logic [VALUE_WIDTH-1:0] n_data;
    logic                   r_gt;
    logic                   r_eq;
    logic                   w_valid;
    logic                   w_hit;
    logic                   w_at;

    // Compare against the operand when an item is taken in.
    always_ff @(posedge i_clk) begin
        if (i_cap) begin
            r_gt <= $signed(r_data) > $signed(i_cmp_value);
            r_eq <= r_data == i_cmp_value;
        end
    end

    assign w_valid = IDX_C < i_count;

    // Decide whether this cell is a candidate position for the operation.
    always_comb begin
        unique case (i_ctl.mode)
            bsle_pkg::MODE_INS_HEAD,
            bsle_pkg::MODE_RM_HEAD:  w_hit = IDX_C == '0;
            bsle_pkg::MODE_INS_TAIL: w_hit = IDX_C == i_count;
            bsle_pkg::MODE_RM_TAIL:  w_hit = IDX_C == (i_count - CW'(1));
            bsle_pkg::MODE_INS_SORT: w_hit = (w_valid && r_gt) || (IDX_C == i_count);
            bsle_pkg::MODE_RM_VALUE: w_hit = w_valid && r_eq;
            default:                 w_hit = 1'b0;
        endcase
    end

    // Only the first candidate along the chain is the position.
    assign w_at    = w_hit && !i_before;
    assign o_after = i_before || w_hit;

    // Shift from the left on insert, from the right on removal.
    always_comb begin
        n_data = r_data;
        if (i_ctl.ins_en) begin
            if (i_before) begin
                n_data = i_prev_data;
            end else if (w_at) begin
                n_data = i_ins_value;
            end
        end else if (i_ctl.rm_en) begin
            if (i_before || w_at) begin
                n_data = i_next_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

FILE: verif/bounded_sorted_list_engine_core_test.sv
// Self-checking testbench for the bounded sorted list engine core.
// Depends on bsle_pkg and bounded_sorted_list_engine_core; reads no files.
`timescale 1ns / 1ps

module bounded_sorted_list_engine_core_test;

    localparam int PVW = bsle_pkg::PORT_VW;
    localparam int CNW = bsle_pkg::COUNT_W;

    // The mode field has one code left over; the block treats it as a no-op.
    localparam bsle_pkg::t_mode MODE_UNUSED = 3'd7;

    localparam logic [PVW-1:0] VAL_MAX  = 32'h7FFF_FFFF;
    localparam logic [PVW-1:0] VAL_MIN  = 32'h8000_0000;
    localparam logic [PVW-1:0] VAL_NEG1 = 32'hFFFF_FFFF;

    typedef struct packed {
        bsle_pkg::t_status    status;
        logic [PVW-1:0]       head_value;
        logic [PVW-1:0]       tail_value;
        logic [CNW-1:0]       count;
    } t_list_report;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            start;
    logic                            busy;
    logic [bsle_pkg::MODE_W-1:0]     i_mode;
    logic [PVW-1:0]                  i_value;
    logic                            o_valid;
    logic [bsle_pkg::STATUS_W-1:0]   o_status;
    logic [PVW-1:0]                  o_head_value;
    logic [PVW-1:0]                  o_tail_value;
    logic [CNW-1:0]                  o_count;

    // Shadow copy of the list contents, head at index 0.
    logic signed [PVW-1:0] shadow_list[$];
    // Reports still owed by the block, oldest first.
    t_list_report          pending_reports[$];

    int fail_count    = 0;
    int items_sent    = 0;
    int reports_seen  = 0;
    int full_drops    = 0;
    int empty_noops   = 0;
    int value_misses  = 0;
    int gap_pct       = 21;

    bounded_sorted_list_engine_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_mode       (i_mode),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_head_value (o_head_value),
        .o_tail_value (o_tail_value),
        .o_count      (o_count)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Applies one operation to the shadow list and queues the report it should give.
    function automatic void predict_list_op(input bsle_pkg::t_mode op,
                                            input logic signed [PVW-1:0] v);
        bsle_pkg::t_status st;
        int                pos;
        t_list_report      rep;
        st = bsle_pkg::ST_OK;
        case (op)
            bsle_pkg::MODE_INS_HEAD: begin
                if (shadow_list.size() >= bsle_pkg::DEPTH_DEF) st = bsle_pkg::ST_FULL;
                else shadow_list.push_front(v);
            end
            bsle_pkg::MODE_INS_TAIL: begin
                if (shadow_list.size() >= bsle_pkg::DEPTH_DEF) st = bsle_pkg::ST_FULL;
                else shadow_list.push_back(v);
            end
            bsle_pkg::MODE_RM_HEAD: begin
                if (shadow_list.size() == 0) st = bsle_pkg::ST_EMPTY;
                else void'(shadow_list.pop_front());
            end
            bsle_pkg::MODE_RM_TAIL: begin
                if (shadow_list.size() == 0) st = bsle_pkg::ST_EMPTY;
                else void'(shadow_list.pop_back());
            end
            bsle_pkg::MODE_INS_SORT: begin
                if (shadow_list.size() >= bsle_pkg::DEPTH_DEF) begin
                    st = bsle_pkg::ST_FULL;
                end else begin
                    // Goes in front of the first element strictly greater.
                    pos = shadow_list.size();
                    for (int k = shadow_list.size() - 1; k >= 0; k--)
                        if (shadow_list[k] > v) pos = k;
                    shadow_list.insert(pos, v);
                end
            end
            bsle_pkg::MODE_RM_VALUE: begin
                if (shadow_list.size() == 0) begin
                    st = bsle_pkg::ST_EMPTY;
                end else begin
                    pos = -1;
                    for (int k = shadow_list.size() - 1; k >= 0; k--)
                        if (shadow_list[k] == v) pos = k;
                    if (pos >= 0) shadow_list.delete(pos);
                    else st = bsle_pkg::ST_NOT_FOUND;
                end
            end
            bsle_pkg::MODE_CLEAR: shadow_list.delete();
            default: ;
        endcase

        if (st == bsle_pkg::ST_FULL) full_drops++;
        if (st == bsle_pkg::ST_EMPTY) empty_noops++;
        if (st == bsle_pkg::ST_NOT_FOUND) value_misses++;

        rep.status     = st;
        rep.count      = CNW'(shadow_list.size());
        rep.head_value = (shadow_list.size() == 0) ? '0 : shadow_list[0];
        rep.tail_value = (shadow_list.size() == 0) ? '0 : shadow_list[shadow_list.size() - 1];
        pending_reports.push_back(rep);
    endfunction

    // Offers one item, with an occasional random gap first, and waits for it to be taken.
    task automatic send_op(input bsle_pkg::t_mode op, input logic [PVW-1:0] operand);
        int gap;
        if ($urandom_range(0, 99) < gap_pct) begin
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_mode  <= op;
        i_value <= operand;
        do @(posedge i_clk); while (busy);
        items_sent++;
        predict_list_op(op, operand);
    endtask

    // Holds the sender off until the block has reported on everything it took.
    task automatic hold_until_drained();
        int waited;
        waited = 0;
        start <= 1'b0;
        while (pending_reports.size() != 0 && waited < 200) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Removal and no-op behaviour on an empty list.
    task automatic test_empty_list();
        send_op(bsle_pkg::MODE_RM_TAIL, 32'd0);
        send_op(bsle_pkg::MODE_RM_VALUE, VAL_MIN);
    endtask

    // Fills the list with extreme and duplicate values, then tries every insert on it.
    task automatic test_full_list();
        int k;
        send_op(bsle_pkg::MODE_INS_HEAD, VAL_MAX);
        send_op(bsle_pkg::MODE_INS_TAIL, VAL_MIN);
        send_op(bsle_pkg::MODE_INS_SORT, 32'd0);
        send_op(bsle_pkg::MODE_INS_SORT, VAL_NEG1);
        send_op(bsle_pkg::MODE_INS_SORT, 32'd0);
        send_op(bsle_pkg::MODE_INS_SORT, VAL_MAX);
        send_op(bsle_pkg::MODE_INS_SORT, VAL_MIN);
        k = 0;
        while (shadow_list.size() < bsle_pkg::DEPTH_DEF) begin
            send_op(bsle_pkg::MODE_INS_SORT,
                    (k % 2) ? (32'hAAAA_AAAA ^ k) : (32'h5555_5555 + k));
            k++;
        end
        send_op(bsle_pkg::MODE_INS_HEAD, 32'd1);
        send_op(bsle_pkg::MODE_INS_TAIL, 32'd2);
        send_op(bsle_pkg::MODE_INS_SORT, 32'd3);
    endtask

    // Value search, end removals, clearing and the one-element tail removal.
    task automatic test_removals();
        send_op(bsle_pkg::MODE_RM_VALUE, 32'd12345);
        send_op(bsle_pkg::MODE_RM_VALUE, 32'd0);
        send_op(bsle_pkg::MODE_RM_HEAD, 32'd0);
        send_op(bsle_pkg::MODE_RM_TAIL, 32'd0);
        send_op(bsle_pkg::MODE_CLEAR, 32'd0);
        send_op(MODE_UNUSED, VAL_NEG1);
        send_op(bsle_pkg::MODE_INS_TAIL, 32'd42);
        send_op(bsle_pkg::MODE_RM_TAIL, 32'd0);
        send_op(bsle_pkg::MODE_RM_HEAD, 32'd0);
        send_op(bsle_pkg::MODE_CLEAR, 32'd0);
    endtask

    // Random traffic; ins_pct tilts the mix towards growing or shrinking the list.
    task automatic test_random_traffic(input int n_items, input int ins_pct);
        bsle_pkg::t_mode    op;
        logic [PVW-1:0]     operand;
        int                 r;
        for (int n = 0; n < n_items; n++) begin
            r = $urandom_range(0, 99);
            if (r < ins_pct) begin
                case ($urandom_range(0, 2))
                    0: op = bsle_pkg::MODE_INS_HEAD;
                    1: op = bsle_pkg::MODE_INS_TAIL;
                    default: op = bsle_pkg::MODE_INS_SORT;
                endcase
            end else if (r < 98) begin
                case ($urandom_range(0, 2))
                    0: op = bsle_pkg::MODE_RM_HEAD;
                    1: op = bsle_pkg::MODE_RM_TAIL;
                    default: op = bsle_pkg::MODE_RM_VALUE;
                endcase
            end else if (r == 98) begin
                op = bsle_pkg::MODE_CLEAR;
            end else begin
                op = MODE_UNUSED;
            end

            // Small values give duplicates and hits; full-width values exercise every bit.
            case ($urandom_range(0, 3))
                0, 1: operand = $urandom_range(0, 8) - 4;
                2: operand = $urandom;
                default: begin
                    case ($urandom_range(0, 3))
                        0: operand = VAL_MAX;
                        1: operand = VAL_MIN;
                        2: operand = VAL_NEG1;
                        default: operand = '0;
                    endcase
                end
            endcase
            if (op == bsle_pkg::MODE_RM_VALUE && shadow_list.size() != 0
                && $urandom_range(0, 1))
                operand = shadow_list[$urandom_range(0, shadow_list.size() - 1)];

            send_op(op, operand);
        end
    endtask

    // Compares every report with the oldest one still owed.
    always @(posedge i_clk) begin : check_reports
        t_list_report want;
        if (i_rst_n && o_valid) begin
            reports_seen++;
            if (pending_reports.size() == 0) begin
                $error("Report with none owed: status %0d count %0d", o_status, o_count);
                fail_count++;
            end else begin
                want = pending_reports.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    fail_count++;
                end
                if (o_head_value !== want.head_value) begin
                    $error("head_value: expected %0d, got %0d",
                           $signed(want.head_value), $signed(o_head_value));
                    fail_count++;
                end
                if (o_tail_value !== want.tail_value) begin
                    $error("tail_value: expected %0d, got %0d",
                           $signed(want.tail_value), $signed(o_tail_value));
                    fail_count++;
                end
                if (o_count !== want.count) begin
                    $error("count: expected %0d, got %0d", want.count, o_count);
                    fail_count++;
                end
            end
        end
    end

    // Test sequence.
    initial begin
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_mode  <= bsle_pkg::MODE_INS_HEAD;
        i_value <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_list();
        test_full_list();
        test_removals();

        gap_pct = 21;
        test_random_traffic(200, 65);
        hold_until_drained();

        // A long stretch with the sender never idling.
        gap_pct = 0;
        test_random_traffic(150, 50);

        gap_pct = 21;
        test_random_traffic(250, 40);

        hold_until_drained();
        repeat (8) @(posedge i_clk);
        if (pending_reports.size() != 0) begin
            $error("%0d reports never arrived", pending_reports.size());
            fail_count++;
        end

        $display("Sent %0d items, checked %0d reports: %0d full drops, %0d empty no-ops,",
                 items_sent, reports_seen, full_drops, empty_noops);
        $display("and %0d value misses across growing, shrinking and back-to-back traffic.",
                 value_misses);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
